// File: rtl/bdsl_pkg.sv
// bdsl_pkg: shared types, register codes and reset values for the button
// debounce unit with short and long press detection.
// No dependencies; every rtl file imports it.
package bdsl_pkg;

   // default sizes handed to the top-level parameters
   localparam int NUM_BUTTONS_DEF = 5;
   localparam int TIME_BITS_DEF   = 32;

   // fixed field widths
   localparam int PIN_BITS   = 5;
   localparam int FILT_BITS  = 16;
   localparam int IDLE_BITS  = 32;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int REG_IDX_W  = 3;

   // register indexes (byte address = 4 * index)
   localparam logic [REG_IDX_W-1:0] REG_FILTER_TICKS = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_LONG_TICKS   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_SHORT_ENABLE = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_LONG_ENABLE  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_IDLE_LIMIT   = 3'd4;

   // register reset values
   localparam logic [FILT_BITS-1:0] FILTER_TICKS_RST = 16'd50;
   localparam logic [FILT_BITS-1:0] LONG_TICKS_RST   = 16'd1000;
   localparam logic [PIN_BITS-1:0]  SHORT_ENABLE_RST = 5'd31;
   localparam logic [PIN_BITS-1:0]  LONG_ENABLE_RST  = 5'd0;
   localparam logic [IDLE_BITS-1:0] IDLE_LIMIT_RST   = 32'd0;

   // input item
   typedef struct packed {
      logic [PIN_BITS-1:0] pin_levels;
      logic                arm_hold;
   } req_type;

   // result item
   typedef struct packed {
      logic [PIN_BITS-1:0] short_events;
      logic [PIN_BITS-1:0] long_events;
      logic                hold_fire;
      logic                active;
      logic                any_pressed;
   } rsp_type;

   // configuration register set
   typedef struct packed {
      logic [FILT_BITS-1:0] filter_ticks;
      logic [FILT_BITS-1:0] long_ticks;
      logic [PIN_BITS-1:0]  short_enable;
      logic [PIN_BITS-1:0]  long_enable;
      logic [IDLE_BITS-1:0] idle_limit;
   } cfg_type;

   // what one button lane reports for the current item
   typedef struct packed {
      logic short_evt;
      logic long_evt;
      logic changed;
      logic pushed;
   } lane_status_type;

endpackage

// File: rtl/bdsl_csr.sv
// bdsl_csr: APB-style configuration registers of the debounce unit.
// Depends on bdsl_pkg.
module bdsl_csr
   import bdsl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type              cfg_ff;
   cfg_type              cfg_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign cfg        = cfg_ff;

   // register write decode, writes past the last register are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_FILTER_TICKS: cfg_in.filter_ticks = csr_pwdata[FILT_BITS-1:0];
            REG_LONG_TICKS:   cfg_in.long_ticks   = csr_pwdata[FILT_BITS-1:0];
            REG_SHORT_ENABLE: cfg_in.short_enable = csr_pwdata[PIN_BITS-1:0];
            REG_LONG_ENABLE:  cfg_in.long_enable  = csr_pwdata[PIN_BITS-1:0];
            REG_IDLE_LIMIT:   cfg_in.idle_limit   = csr_pwdata[IDLE_BITS-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.filter_ticks <= FILTER_TICKS_RST;
         cfg_ff.long_ticks   <= LONG_TICKS_RST;
         cfg_ff.short_enable <= SHORT_ENABLE_RST;
         cfg_ff.long_enable  <= LONG_ENABLE_RST;
         cfg_ff.idle_limit   <= IDLE_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back
   always_comb begin
      case (reg_idx)
         REG_FILTER_TICKS: csr_prdata = CSR_DATA_W'(cfg_ff.filter_ticks);
         REG_LONG_TICKS:   csr_prdata = CSR_DATA_W'(cfg_ff.long_ticks);
         REG_SHORT_ENABLE: csr_prdata = CSR_DATA_W'(cfg_ff.short_enable);
         REG_LONG_ENABLE:  csr_prdata = CSR_DATA_W'(cfg_ff.long_enable);
         REG_IDLE_LIMIT:   csr_prdata = CSR_DATA_W'(cfg_ff.idle_limit);
         default:          csr_prdata = '0;
      endcase
   end

endmodule

// File: rtl/bdsl_lane.sv
// bdsl_lane: debounce and short/long press detection for one button.
// Depends on bdsl_pkg; one copy per button under the top level.
module bdsl_lane
   import bdsl_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic                 level,
   input  logic                 short_en,
   input  logic                 long_en,
   input  logic [TIME_BITS-1:0] tm,
   input  logic [FILT_BITS-1:0] filter_ticks,
   input  logic [FILT_BITS-1:0] long_ticks,
   output lane_status_type      status
);

   logic                 last_level_ff, last_level_in;
   logic [TIME_BITS-1:0] change_time_ff, change_time_in;
   logic [TIME_BITS-1:0] press_time_ff, press_time_in;
   logic                 press_valid_ff, press_valid_in;
   logic                 event_done_ff, event_done_in;

   logic                 changed;
   logic                 pushed;
   logic [TIME_BITS-1:0] since_change;
   logic [TIME_BITS-1:0] since_press;
   logic                 filter_ok;
   logic                 long_ok;
   logic                 just_pressed;
   logic                 done_mid;
   logic                 valid_mid;
   logic                 short_evt;
   logic                 long_evt;

   assign changed = level ^ last_level_ff;
   assign pushed  = ~level;

   // elapsed times wrap at the time width
   assign since_change = tm - change_time_ff;
   assign since_press  = tm - press_time_ff;
   assign filter_ok    = since_change > TIME_BITS'(filter_ticks);
   assign long_ok      = since_press > TIME_BITS'(long_ticks);

   // filtered press and release
   always_comb begin
      last_level_in  = last_level_ff;
      change_time_in = change_time_ff;
      press_time_in  = press_time_ff;
      valid_mid      = press_valid_ff;
      done_mid       = event_done_ff;
      just_pressed   = 1'b0;
      short_evt      = 1'b0;
      if (changed) begin
         last_level_in  = level;
         change_time_in = tm;
         if (pushed && filter_ok) begin
            press_time_in = tm;
            valid_mid     = 1'b1;
            just_pressed  = 1'b1;
            if (!event_done_ff && short_en && !long_en) begin
               short_evt = 1'b1;
               done_mid  = 1'b1;
            end
         end
      end else if (!pushed && press_valid_ff && filter_ok) begin
         if (!event_done_ff && short_en && long_en) begin
            short_evt = 1'b1;
         end
         valid_mid = 1'b0;
         done_mid  = 1'b0;
      end
   end

   // long press; a press taken on this tick has zero elapsed time
   assign long_evt = !done_mid && long_en && pushed && valid_mid && !just_pressed && long_ok;

   assign press_valid_in = valid_mid;
   assign event_done_in  = done_mid | long_evt;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_level_ff  <= 1'b1;
         change_time_ff <= '0;
         press_time_ff  <= '0;
         press_valid_ff <= 1'b0;
         event_done_ff  <= 1'b0;
      end else if (step) begin
         last_level_ff  <= last_level_in;
         change_time_ff <= change_time_in;
         press_time_ff  <= press_time_in;
         press_valid_ff <= press_valid_in;
         event_done_ff  <= event_done_in;
      end
   end

   assign status.short_evt = short_evt;
   assign status.long_evt  = long_evt;
   assign status.changed   = changed;
   assign status.pushed    = pushed;

endmodule

// File: rtl/bdsl_merge.sv
// bdsl_merge: tick counter, idle counter and hold repeat, merging of the
// lane results and the output register with the channel handshake.
// Depends on bdsl_pkg; consumes the status of every bdsl_lane.
module bdsl_merge
   import bdsl_pkg::*;
#(
   parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
   parameter int TIME_BITS   = TIME_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  req_type                           req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output rsp_type                           rsp_data,
   input  cfg_type                           cfg,
   input  lane_status_type [NUM_BUTTONS-1:0] lane_status,
   output logic                              step,
   output logic [TIME_BITS-1:0]              tm
);

   logic [TIME_BITS-1:0] now_ticks_ff;
   logic [IDLE_BITS-1:0] idle_count_ff, idle_count_in;
   logic                 hold_armed_ff, hold_armed_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                 any_change;
   logic                 any_pushed;
   logic [IDLE_BITS-1:0] idle_bumped;
   logic [PIN_BITS-1:0]  shorts;
   logic [PIN_BITS-1:0]  longs;

   // one-deep output register: accept whenever it is free or being emptied
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign step      = req_valid & ~req_stall;
   assign tm        = now_ticks_ff + TIME_BITS'(1);

   // combine the lanes
   always_comb begin
      any_change = 1'b0;
      any_pushed = 1'b0;
      for (int k = 0; k < NUM_BUTTONS; k++) begin
         any_change = any_change | lane_status[k].changed;
         any_pushed = any_pushed | lane_status[k].pushed;
      end
   end

   // event bits of buttons past the field width are dropped
   for (genvar k = 0; k < PIN_BITS; k++) begin : g_evt
      if (k < NUM_BUTTONS) begin : g_on
         assign shorts[k] = lane_status[k].short_evt;
         assign longs[k]  = lane_status[k].long_evt;
      end else begin : g_off
         assign shorts[k] = 1'b0;
         assign longs[k]  = 1'b0;
      end
   end

   // idle counter saturates and holds while the hold repeat is armed; any raw change restarts it
   assign idle_bumped   = (hold_armed_ff || (&idle_count_ff)) ? idle_count_ff
                                                              : idle_count_ff + IDLE_BITS'(1);
   assign idle_count_in = any_change ? '0 : idle_bumped;

   // hold repeat: cleared by a raw change, armed only while a pin is pressed
   assign hold_armed_in = (hold_armed_ff & ~any_change) | (req_data.arm_hold & any_pushed);

   // result of this item
   always_comb begin
      rsp_data_in.short_events = shorts;
      rsp_data_in.long_events  = longs;
      rsp_data_in.hold_fire    = hold_armed_ff;
      rsp_data_in.active       = idle_count_in <= cfg.idle_limit;
      rsp_data_in.any_pressed  = any_pushed;
   end

   always_comb begin
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ticks_ff  <= '0;
         idle_count_ff <= '0;
         hold_armed_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            now_ticks_ff  <= tm;
            idle_count_ff <= idle_count_in;
            hold_armed_ff <= hold_armed_in;
         end
      end
   end

   // payload register
   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/button_debounce_short_long_press_unit.sv
// Button debounce unit with short and long press detection, one item per
// millisecond tick carrying the raw active-low pins of the buttons in the pin field.
// Depends on bdsl_pkg, bdsl_csr, bdsl_lane and bdsl_merge.
//
// Each accepted item advances the tick counter and is filtered by one lane per
// button, all lanes working side by side; the merge stage folds their results
// into the idle counter, the hold-repeat flag and one result item. The unit
// accepts one item every cycle unless a stalled result fills its single
// output register, which holds back the next item only while it waits. There
// is no clearing pass after reset. Registers are to be written through the
// csr port while no item is in flight; the block itself does not enforce it.
module button_debounce_short_long_press_unit
   import bdsl_pkg::*;
#(
   parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
   parameter int TIME_BITS   = TIME_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type                           cfg;
   lane_status_type [NUM_BUTTONS-1:0] lane_status;
   logic                              step;
   logic [TIME_BITS-1:0]              tm;

   // configuration registers
   bdsl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // one lane per button; buttons past the pin field read as pressed
   for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
      logic level;
      logic short_en;
      logic long_en;

      if (i < PIN_BITS) begin : g_pin
         assign level    = req_data.pin_levels[i];
         assign short_en = cfg.short_enable[i];
         assign long_en  = cfg.long_enable[i];
      end else begin : g_extra
         assign level    = 1'b0;
         assign short_en = 1'b0;
         assign long_en  = 1'b0;
      end

      bdsl_lane #(
         .TIME_BITS (TIME_BITS)
      ) u_lane (
         .clock        (clock),
         .reset        (reset),
         .step         (step),
         .level        (level),
         .short_en     (short_en),
         .long_en      (long_en),
         .tm           (tm),
         .filter_ticks (cfg.filter_ticks),
         .long_ticks   (cfg.long_ticks),
         .status       (lane_status[i])
      );
   end

   // global state, merging and output register
   bdsl_merge #(
      .NUM_BUTTONS (NUM_BUTTONS),
      .TIME_BITS   (TIME_BITS)
   ) u_merge (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .cfg         (cfg),
      .lane_status (lane_status),
      .step        (step),
      .tm          (tm)
   );

endmodule

// File: rtl/bdsl_checker.sv
// bdsl_checker: port-level assertions for the button debounce unit, bound
// to the top level. Depends on bdsl_pkg and button_debounce_short_long_press_unit.
module bdsl_checker
   import bdsl_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   logic req_take;
   assign req_take = req_valid & ~req_stall;

   // no result is left over from before reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // results come only from items
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      !req_take && !(rsp_valid && rsp_stall) |=> !rsp_valid)
      else $error("result without an item");

   // a pressed pin shows in the result of its item
   a_any_pressed: assert property (@(posedge clock) disable iff (reset)
      req_take && (req_data.pin_levels != '1) |=> rsp_valid && rsp_data.any_pressed)
      else $error("pressed pin not reported");

   // a button never raises a short and a long event on the same tick
   a_evt_disjoint: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.short_events & rsp_data.long_events) == '0)
      else $error("short and long event on the same button");

endmodule

bind button_debounce_short_long_press_unit bdsl_checker u_checker (.*);

// File: tb/sv/button_debounce_short_long_press_unit_test.sv
// Self-checking testbench for button_debounce_short_long_press_unit: a short
// table of ticks, then random press episodes under several register settings.
// Depends on bdsl_pkg and the rtl of the unit.
`timescale 1ns / 1ps

module button_debounce_short_long_press_unit_test;
   import bdsl_pkg::*;

   localparam int NUM_PHASES    = 6;
   localparam int PHASE_ITEMS   = 315;
   localparam int DIR_ROWS      = 20;
   localparam int DIR_SPLIT     = 6;
   localparam int SETTLE_CYCLES = 4;
   localparam int TIMEOUT_NS    = 5_000_000;

   // register index past the end of the map, writes to it have no effect
   localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd5;

   typedef struct packed {
      req_type stim;
      logic    typed;
      rsp_type want;
   } dir_row_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_type               req_data    = '1;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // predictor copy of the registers and the per-button state
   cfg_type                  live_cfg = '{FILTER_TICKS_RST, LONG_TICKS_RST, SHORT_ENABLE_RST,
                                          LONG_ENABLE_RST, IDLE_LIMIT_RST};
   logic [TIME_BITS_DEF-1:0] now_ticks = '0;
   logic [IDLE_BITS-1:0]     idle_cnt  = '0;
   logic                     hold_on   = 1'b0;
   logic [PIN_BITS-1:0]      lvl_q     = '1;
   logic [TIME_BITS_DEF-1:0] chg_at     [PIN_BITS] = '{default: '0};
   logic [TIME_BITS_DEF-1:0] pressed_at [PIN_BITS] = '{default: '0};
   logic [PIN_BITS-1:0]      press_ok  = '0;
   logic [PIN_BITS-1:0]      evt_taken = '0;

   rsp_type pending_rsp[$];
   int      err_count     = 0;
   int      items_sent    = 0;
   int      rsp_seen      = 0;
   int      shorts_seen   = 0;
   int      longs_seen    = 0;
   int      fires_seen    = 0;
   int      send_idle_pct = 20;
   int      recv_idle_pct = 61;

   // first rows run with reset registers, the rest with a fast setting
   dir_row_type dir_rows [DIR_ROWS] = '{
      '{'{5'b11111, 1'b0}, 1'b1, '{5'd0, 5'd0, 1'b0, 1'b0, 1'b0}},
      '{'{5'b11110, 1'b1}, 1'b1, '{5'd0, 5'd0, 1'b0, 1'b1, 1'b1}},
      '{'{5'b11110, 1'b0}, 1'b1, '{5'd0, 5'd0, 1'b1, 1'b1, 1'b1}},
      '{'{5'b11110, 1'b0}, 1'b1, '{5'd0, 5'd0, 1'b1, 1'b1, 1'b1}},
      '{'{5'b11111, 1'b0}, 1'b1, '{5'd0, 5'd0, 1'b1, 1'b1, 1'b0}},
      '{'{5'b11111, 1'b1}, 1'b1, '{5'd0, 5'd0, 1'b0, 1'b0, 1'b0}},
      '{'{5'b00000, 1'b0}, 1'b0, '0},
      '{'{5'b00000, 1'b0}, 1'b0, '0},
      '{'{5'b11111, 1'b0}, 1'b0, '0},
      '{'{5'b11111, 1'b0}, 1'b0, '0},
      '{'{5'b00000, 1'b0}, 1'b0, '0},
      '{'{5'b11111, 1'b0}, 1'b0, '0},
      '{'{5'b11111, 1'b0}, 1'b0, '0},
      '{'{5'b01010, 1'b1}, 1'b0, '0},
      '{'{5'b01010, 1'b0}, 1'b0, '0},
      '{'{5'b10101, 1'b0}, 1'b0, '0},
      '{'{5'b10101, 1'b1}, 1'b0, '0},
      '{'{5'b10101, 1'b0}, 1'b0, '0},
      '{'{5'b11111, 1'b0}, 1'b0, '0},
      '{'{5'b11111, 1'b1}, 1'b0, '0}
   };

   // zero filter and hold time, idle limit at its top
   cfg_type dir_cfg = '{16'd0, 16'd0, 5'b11111, 5'b10101, 32'hFFFF_FFFF};

   cfg_type phase_cfg [NUM_PHASES] = '{
      '{16'd2,     16'd8,     5'b11111, 5'b00111, 32'd3},
      '{16'd0,     16'd0,     5'b10110, 5'b11111, 32'd0},
      '{16'd65535, 16'd65535, 5'b00000, 5'b00000, 32'hFFFF_FFFF},
      '{16'd1,     16'd20,    5'b01101, 5'b11010, 32'd10},
      '{16'd4,     16'd3,     5'b11111, 5'b11111, 32'd1},
      '{16'd3,     16'd12,    5'b11111, 5'b00101, 32'd50}
   };

   button_debounce_short_long_press_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // one tick of the debounce logic: advances the predictor state
   function automatic rsp_type step_buttons(req_type r);
      rsp_type                  o;
      logic [TIME_BITS_DEF-1:0] t;
      logic [TIME_BITS_DEF-1:0] since_chg;
      logic [TIME_BITS_DEF-1:0] since_press;
      logic                     lvl;
      logic                     pushed;
      logic                     sen;
      logic                     len;
      o = '0;
      now_ticks = now_ticks + TIME_BITS_DEF'(1);
      t = now_ticks;
      o.hold_fire = hold_on;
      if (!hold_on && idle_cnt != '1) begin
         idle_cnt = idle_cnt + IDLE_BITS'(1);
      end
      for (int b = 0; b < PIN_BITS; b++) begin
         lvl = r.pin_levels[b];
         pushed = !lvl;
         sen = live_cfg.short_enable[b];
         len = live_cfg.long_enable[b];
         since_chg = t - chg_at[b];
         if (pushed) begin
            o.any_pressed = 1'b1;
         end
         if (lvl != lvl_q[b]) begin
            // any raw edge kills the hold repeat and the idle count
            hold_on = 1'b0;
            idle_cnt = '0;
            if (pushed && since_chg > live_cfg.filter_ticks) begin
               pressed_at[b] = t;
               press_ok[b] = 1'b1;
               if (!evt_taken[b] && sen && !len) begin
                  o.short_events[b] = 1'b1;
                  evt_taken[b] = 1'b1;
               end
            end
            chg_at[b] = t;
            lvl_q[b] = lvl;
         end else if (!pushed && press_ok[b] && since_chg > live_cfg.filter_ticks) begin
            // settled release: short event here for long-press buttons
            if (!evt_taken[b] && sen && len) begin
               o.short_events[b] = 1'b1;
            end
            press_ok[b] = 1'b0;
            evt_taken[b] = 1'b0;
         end
         since_press = t - pressed_at[b];
         if (!evt_taken[b] && len && pushed && press_ok[b] &&
             since_press > live_cfg.long_ticks) begin
            o.long_events[b] = 1'b1;
            evt_taken[b] = 1'b1;
         end
      end
      if (r.arm_hold && o.any_pressed) begin
         hold_on = 1'b1;
      end
      o.active = (idle_cnt <= live_cfg.idle_limit);
      return o;
   endfunction

   // present one item, hold it until taken, then queue what it should give
   task automatic send_item(input req_type r, input logic typed = 1'b0,
                            input rsp_type want = '0);
      rsp_type pred;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      pred = step_buttons(r);
      pending_rsp.push_back(typed ? want : pred);
      items_sent++;
   endtask

   // stop sending and wait for every outstanding result
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register write then read back
   task automatic set_reg(input logic [REG_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      logic [CSR_DATA_W-1:0] want;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_FILTER_TICKS: live_cfg.filter_ticks = val[FILT_BITS-1:0];
         REG_LONG_TICKS:   live_cfg.long_ticks = val[FILT_BITS-1:0];
         REG_SHORT_ENABLE: live_cfg.short_enable = val[PIN_BITS-1:0];
         REG_LONG_ENABLE:  live_cfg.long_enable = val[PIN_BITS-1:0];
         REG_IDLE_LIMIT:   live_cfg.idle_limit = val[IDLE_BITS-1:0];
         default: ;
      endcase
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_FILTER_TICKS: want = CSR_DATA_W'(live_cfg.filter_ticks);
         REG_LONG_TICKS:   want = CSR_DATA_W'(live_cfg.long_ticks);
         REG_SHORT_ENABLE: want = CSR_DATA_W'(live_cfg.short_enable);
         REG_LONG_ENABLE:  want = CSR_DATA_W'(live_cfg.long_enable);
         REG_IDLE_LIMIT:   want = CSR_DATA_W'(live_cfg.idle_limit);
         default:          want = csr_prdata;
      endcase
      if (csr_prdata !== want) begin
         $error("csr_prdata reg %0d: expected %0h, got %0h", idx, want, csr_prdata);
         err_count++;
      end
   endtask

   task automatic apply_cfg(input cfg_type c);
      set_reg(REG_FILTER_TICKS, CSR_DATA_W'(c.filter_ticks));
      set_reg(REG_LONG_TICKS, CSR_DATA_W'(c.long_ticks));
      set_reg(REG_SHORT_ENABLE, CSR_DATA_W'(c.short_enable));
      set_reg(REG_LONG_ENABLE, CSR_DATA_W'(c.long_enable));
      set_reg(REG_IDLE_LIMIT, CSR_DATA_W'(c.idle_limit));
   endtask

   // quiet release, a press of some buttons with bounce and staggered
   // release, then a released tail
   task automatic press_episode();
      req_type             r;
      logic [PIN_BITS-1:0] held;
      logic [PIN_BITS-1:0] late;
      int                  quiet;
      int                  hold;
      held = PIN_BITS'($urandom_range(1, 31));
      late = $urandom_range(1) ? held : (held & PIN_BITS'($urandom_range(31)));
      quiet = $urandom_range(1, 4) + ((live_cfg.filter_ticks > 12) ? 12 :
                                      int'(live_cfg.filter_ticks));
      hold = $urandom_range(1, 6 + quiet + ((live_cfg.long_ticks > 40) ? 40 :
                                            int'(live_cfg.long_ticks)));
      for (int k = 0; k < quiet; k++) begin
         r.pin_levels = '1;
         r.arm_hold = ($urandom_range(19) == 0);
         send_item(r);
      end
      for (int k = 0; k < hold; k++) begin
         r.pin_levels = ~((k < hold / 2) ? held : late);
         if (k < 2 && $urandom_range(7) == 0) begin
            r.pin_levels ^= held & PIN_BITS'($urandom_range(31));
         end
         r.arm_hold = ($urandom_range(9) == 0);
         send_item(r);
      end
      for (int k = 0; k < quiet; k++) begin
         r.pin_levels = '1;
         if (k == 0 && $urandom_range(5) == 0) begin
            r.pin_levels ^= held & PIN_BITS'($urandom_range(31));
         end
         r.arm_hold = ($urandom_range(19) == 0);
         send_item(r);
      end
   endtask

   // receiver stall
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // result check against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen++;
         if (pending_rsp.size() == 0) begin
            $error("result with nothing expected: %p", rsp_data);
            err_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.short_events !== want.short_events) begin
               $error("short_events: expected %0h, got %0h",
                      want.short_events, rsp_data.short_events);
               err_count++;
            end
            if (rsp_data.long_events !== want.long_events) begin
               $error("long_events: expected %0h, got %0h",
                      want.long_events, rsp_data.long_events);
               err_count++;
            end
            if (rsp_data.hold_fire !== want.hold_fire) begin
               $error("hold_fire: expected %0b, got %0b", want.hold_fire, rsp_data.hold_fire);
               err_count++;
            end
            if (rsp_data.active !== want.active) begin
               $error("active: expected %0b, got %0b", want.active, rsp_data.active);
               err_count++;
            end
            if (rsp_data.any_pressed !== want.any_pressed) begin
               $error("any_pressed: expected %0b, got %0b",
                      want.any_pressed, rsp_data.any_pressed);
               err_count++;
            end
            shorts_seen += $countones(rsp_data.short_events);
            longs_seen += $countones(rsp_data.long_events);
            fires_seen += int'(rsp_data.hold_fire);
         end
      end
   end

   initial begin
      req_type r;
      int      target;
      logic    paused;
      paused = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed ticks
      for (int i = 0; i < DIR_ROWS; i++) begin
         if (i == DIR_SPLIT) begin
            drain_results();
            apply_cfg(dir_cfg);
            set_reg(REG_UNUSED, '1);
         end
         send_item(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
      end

      // random press episodes and noise under each setting
      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p < 2) begin
            send_idle_pct = 20;
            recv_idle_pct = 61;
         end else if (p < 4) begin
            send_idle_pct = 61;
            recv_idle_pct = 20;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         drain_results();
         apply_cfg(phase_cfg[p]);
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) begin
            if ($urandom_range(4) == 0) begin
               repeat ($urandom_range(1, 6)) begin
                  r.pin_levels = PIN_BITS'($urandom_range(31));
                  r.arm_hold = 1'($urandom_range(1));
                  send_item(r);
               end
            end else begin
               press_episode();
            end
            // one pause mid-phase until the pipe is empty
            if (p == 1 && !paused && items_sent > target - PHASE_ITEMS / 2) begin
               drain_results();
               paused = 1'b1;
            end
         end
      end

      drain_results();
      $display("ran %0d ticks over %0d register settings, %0d results checked",
               items_sent, NUM_PHASES + 2, rsp_seen);
      $display("saw %0d short events, %0d long events, %0d hold repeat fires",
               shorts_seen, longs_seen, fires_seen);
      if (err_count == 0) begin
         $display("button_debounce_short_long_press_unit_test: done, clean");
      end else begin
         $display("button_debounce_short_long_press_unit_test: done, errors");
      end
      $finish;
   end

   // hang guard
   initial begin
      #(TIMEOUT_NS);
      $display("button_debounce_short_long_press_unit_test: done, errors");
      $finish;
   end

endmodule
